FILE: src/periodic_timer_queue_macros.svh
// Assertion macros for the periodic timer queue.
// Used by the top level; no other dependencies.
`ifndef PERIODIC_TIMER_QUEUE_MACROS_SVH
`define PERIODIC_TIMER_QUEUE_MACROS_SVH
// Assert that a condition implies a consequence on the same edge.
`define PTQ_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence on the next edge.
`define PTQ_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/ptq_pkg.sv
// Package for the periodic timer queue: widths, codes, the sequencer states and a saturating add.
// No dependencies.
`timescale 1ns / 1ps
package ptq_pkg;
    localparam int TIME_W = 48;
    localparam int ID_W = 32;
    localparam int DEF_CAPACITY = 16;
    localparam int DEF_MAX_FIRES = 16;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_DEL = 2'd1,
        FN_EXP = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        K_ADDED = 3'd0,
        K_DELETED = 3'd1,
        K_NOT_FOUND = 3'd2,
        K_FULL = 3'd3,
        K_FIRED = 3'd4,
        K_NONE = 3'd5
    } t_kind;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_ACT = 6'b000100,
        S_NEAR = 6'b001000,
        S_OUT = 6'b010000,
        S_WAIT = 6'b100000
    } t_state;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [ID_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W - ID_W + 1){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction
endpackage

FILE: src/periodic_timer_queue.sv
// Periodic timer queue top level: sequencer, timer stores and stream ports.
// Depends on ptq_pkg and periodic_timer_queue_macros.svh.
// One shared compare unit walks all CAPACITY slots, one slot a cycle.
// Add, full, not_found and none_expired results follow a single walk; a found delete
// or a first fire needs a second walk. Each further fire of a scan needs another walk
// once the previous result is accepted. One item at a time: the next item is taken
// in the cycle after the final result is accepted.
// Reset (synchronous, active low) clears valid bits, the ID counter, the outputs and the FSM.
`timescale 1ns / 1ps
`include "periodic_timer_queue_macros.svh"
module periodic_timer_queue
    import ptq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int MAX_FIRES = DEF_MAX_FIRES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], now_ms[49:2], delay_ms[81:50], period_ms[113:82],
    // target_id[145:114], zero fill up to 151
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[2:0], timer_id[34:3], near_timeout[82:35], zero fill up to 87
    output logic [87:0]  m_axis_tdata,
    // queue_empty[0], front_changed[1]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(MAX_FIRES + 1);

    // timer stores; valid bits in flops, payload in plain registers
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [TIME_W-1:0]   r_dl [CAPACITY];
    logic [ID_W-1:0]     r_per [CAPACITY];
    logic [ID_W-1:0]     r_id [CAPACITY];

    t_state r_state, n_state;
    logic [ID_W-1:0] r_next_id, n_next_id;

    // latched item
    logic [1:0]        r_func;
    logic [TIME_W-1:0] r_now;
    logic [ID_W-1:0]   r_delay, r_per_in, r_tgt;

    // scan unit: running minimum and first free / first match slot
    logic [SW-1:0]     r_idx, n_idx;
    logic              r_bfound, n_bfound;
    logic [SW-1:0]     r_best, n_best;
    logic              r_mfound, n_mfound;
    logic [SW-1:0]     r_match, n_match;
    logic              r_pass2, n_pass2; // second min pass after delete or fire
    logic [FW-1:0]     r_nfired, n_nfired;

    // result register, held while the result waits
    t_kind             r_kind, n_kind;
    logic [ID_W-1:0]   r_oid, n_oid;
    logic              r_fc, n_fc;
    logic              r_last, n_last;
    logic [TIME_W-1:0] r_near;
    logic              r_empty;

    logic              better;
    logic              due;
    logic              more;
    logic              new_front;
    logic [TIME_W-1:0] near;
    logic [TIME_W-1:0] add_dl;
    logic [ID_W-1:0]   add_id;
    logic              wr_dl_en;
    logic              wr_add;
    logic [SW-1:0]     wr_slot;
    logic [TIME_W-1:0] wr_dl;

    // order: deadline, then ID; a strict compare keeps the lower slot on a full tie
    assign better = r_valid[r_idx] && (!r_bfound || r_dl[r_idx] < r_dl[r_best] ||
                    (r_dl[r_idx] == r_dl[r_best] && r_id[r_idx] < r_id[r_best]));
    assign due = r_bfound && r_dl[r_best] <= r_now;
    assign more = due && r_nfired != FW'(MAX_FIRES);
    assign near = (r_bfound && r_dl[r_best] > r_now) ? r_dl[r_best] - r_now : '0;
    assign add_dl = sat_add(r_now, r_delay);
    assign add_id = r_next_id + 1'b1;
    // new timer becomes the front when it orders before the current minimum
    assign new_front = !r_bfound || add_dl < r_dl[r_best] ||
                       (add_dl == r_dl[r_best] && (add_id < r_id[r_best] ||
                       (add_id == r_id[r_best] && r_match < r_best)));

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = (r_state == S_WAIT);
    assign m_axis_tdata = {5'd0, r_near, r_oid, r_kind};
    assign m_axis_tuser = {r_fc, r_empty};
    assign m_axis_tlast = r_last;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_next_id = r_next_id;
        n_idx = r_idx;
        n_bfound = r_bfound;
        n_best = r_best;
        n_mfound = r_mfound;
        n_match = r_match;
        n_pass2 = r_pass2;
        n_nfired = r_nfired;
        n_kind = r_kind;
        n_oid = r_oid;
        n_fc = r_fc;
        n_last = r_last;
        wr_dl_en = 1'b0;
        wr_add = 1'b0;
        wr_slot = r_best;
        wr_dl = sat_add(r_dl[r_best], r_per[r_best]);
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_SCAN;
                    n_idx = '0;
                    n_bfound = 1'b0;
                    n_mfound = 1'b0;
                    n_pass2 = 1'b0;
                    n_nfired = '0;
                end
            end
            S_SCAN: begin
                // one slot per cycle: minimum, first free and first ID match
                if (better) begin
                    n_bfound = 1'b1;
                    n_best = r_idx;
                end
                if (!r_mfound) begin
                    if (r_func == FN_ADD && !r_valid[r_idx]) begin
                        n_mfound = 1'b1;
                        n_match = r_idx;
                    end
                    if (r_func == FN_DEL && r_valid[r_idx] && r_id[r_idx] == r_tgt) begin
                        n_mfound = 1'b1;
                        n_match = r_idx;
                    end
                end
                if (r_idx == SW'(CAPACITY - 1)) begin
                    n_state = S_ACT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ACT: begin
                n_idx = '0;
                n_state = S_NEAR;
                priority if (r_pass2) begin
                    // rescan done: r_best holds the minimum of the updated queue
                    n_pass2 = 1'b0;
                    if (r_func[1]) begin
                        n_last = !more;
                    end
                end else if (r_func == FN_ADD) begin
                    n_last = 1'b1;
                    n_fc = 1'b0;
                    if (r_mfound) begin
                        n_next_id = add_id;
                        n_valid[r_match] = 1'b1;
                        wr_dl_en = 1'b1;
                        wr_add = 1'b1;
                        wr_slot = r_match;
                        wr_dl = add_dl;
                        n_kind = K_ADDED;
                        n_oid = add_id;
                        n_fc = new_front;
                        if (new_front) begin
                            n_bfound = 1'b1;
                            n_best = r_match;
                        end
                    end else begin
                        n_kind = K_FULL;
                        n_oid = '0;
                    end
                end else if (r_func == FN_DEL) begin
                    n_last = 1'b1;
                    n_oid = r_tgt;
                    n_fc = 1'b0;
                    if (r_mfound) begin
                        // drop the timer, then rescan for the new minimum
                        n_valid[r_match] = 1'b0;
                        n_kind = K_DELETED;
                        n_fc = r_best == r_match;
                        n_state = S_SCAN;
                        n_pass2 = 1'b1;
                        n_bfound = 1'b0;
                    end else begin
                        n_kind = K_NOT_FOUND;
                    end
                end else if (more) begin
                    // fire the current minimum: reload or drop, then rescan
                    n_kind = K_FIRED;
                    n_oid = r_id[r_best];
                    n_fc = 1'b0;
                    n_nfired = r_nfired + 1'b1;
                    if (r_per[r_best] != '0) begin
                        wr_dl_en = 1'b1;
                        wr_slot = r_best;
                    end else begin
                        n_valid[r_best] = 1'b0;
                    end
                    n_state = S_SCAN;
                    n_pass2 = 1'b1;
                    n_bfound = 1'b0;
                end else begin
                    n_kind = K_NONE;
                    n_oid = '0;
                    n_fc = 1'b0;
                    n_last = 1'b1;
                end
            end
            S_NEAR: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (m_axis_tready) begin
                    // a fired result that is not last: fire the next due timer
                    n_state = r_last ? S_IDLE : S_ACT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_next_id <= '0;
            r_kind <= K_NONE;
            r_oid <= '0;
            r_fc <= 1'b0;
            r_last <= 1'b0;
            r_near <= '0;
            r_empty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_next_id <= n_next_id;
            r_kind <= n_kind;
            r_oid <= n_oid;
            r_fc <= n_fc;
            r_last <= n_last;
            if (r_state == S_NEAR) begin
                r_near <= near;
                r_empty <= !r_bfound;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= s_axis_tdata[1:0];
            r_now <= s_axis_tdata[49:2];
            r_delay <= s_axis_tdata[81:50];
            r_per_in <= s_axis_tdata[113:82];
            r_tgt <= s_axis_tdata[145:114];
        end
        if (wr_dl_en) begin
            r_dl[wr_slot] <= wr_dl;
        end
        if (wr_add) begin
            r_per[wr_slot] <= r_per_in;
            r_id[wr_slot] <= add_id;
        end
        r_idx <= n_idx;
        r_bfound <= n_bfound;
        r_best <= n_best;
        r_mfound <= n_mfound;
        r_match <= n_match;
        r_pass2 <= n_pass2;
        r_nfired <= n_nfired;
    end

    `PTQ_ASSERT_IMPLY(a_ready_idle, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid, "ready while busy")
    `PTQ_ASSERT_IMPLY(a_empty_near, i_clk, i_rst_n, r_empty, r_near == '0, "near set on empty queue")
    `PTQ_ASSERT_NEXT(a_fire_cap, i_clk, i_rst_n, r_state == S_ACT, r_nfired <= FW'(MAX_FIRES), "fire cap")
endmodule

FILE: verif/tb_periodic_timer_queue.sv
// Testbench for periodic_timer_queue: drives add, delete and expire items, and the unused code 3, over the
// input stream and checks every result against an in-bench timer queue model.
// Depends on ptq_pkg and the periodic_timer_queue RTL.
`timescale 1ns / 1ps
module tb_periodic_timer_queue;
    import ptq_pkg::*;

    localparam int NSLOT = 16;
    localparam int NFIRE = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [47:0] near;
        logic        empty;
        logic        front;
        logic        last;
    } t_res;

    // Timer queue model plus the queue of results it predicts.
    class timer_sb;
        bit          vld[NSLOT];
        logic [47:0] dl[NSLOT];
        logic [31:0] per[NSLOT];
        logic [31:0] tid[NSLOT];
        logic [31:0] id_ctr;
        t_res        pending[$];
        int          errors;

        function void clear();
            foreach (vld[i]) vld[i] = 0;
            id_ctr = 0;
            errors = 0;
        endfunction

        function int front_slot();
            int b;
            b = -1;
            for (int i = 0; i < NSLOT; i++)
                if (vld[i] && (b < 0 || dl[i] < dl[b] || (dl[i] == dl[b] && tid[i] < tid[b])))
                    b = i;
            return b;
        endfunction

        function logic [47:0] sadd(logic [47:0] a, logic [31:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {17'd0, b};
            return s[48] ? TIME_MAX : s[47:0];
        endfunction

        function void push(t_kind k, logic [31:0] id, logic [47:0] now, bit fc);
            t_res r;
            int f;
            f = front_slot();
            r.kind = k;
            r.id = id;
            r.near = (f >= 0 && dl[f] > now) ? dl[f] - now : '0;
            r.empty = (f < 0);
            r.front = fc;
            r.last = 0;
            pending = {pending, r};
        endfunction

        function void note_item(logic [151:0] d);
            logic [1:0]  fn;
            logic [47:0] now;
            logic [31:0] dly, pr, tg;
            int slot, n, f;
            bit wf;
            fn = d[1:0];
            now = d[49:2];
            dly = d[81:50];
            pr = d[113:82];
            tg = d[145:114];
            slot = -1;
            n = 0;
            if (fn == FN_ADD) begin
                for (int i = 0; i < NSLOT; i++)
                    if (!vld[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    push(K_FULL, 0, now, 0);
                end else begin
                    id_ctr++;
                    vld[slot] = 1;
                    dl[slot] = sadd(now, dly);
                    per[slot] = pr;
                    tid[slot] = id_ctr;
                    push(K_ADDED, id_ctr, now, front_slot() == slot);
                end
            end else if (fn == FN_DEL) begin
                for (int i = 0; i < NSLOT; i++)
                    if (vld[i] && tid[i] == tg && slot < 0) slot = i;
                if (slot < 0) begin
                    push(K_NOT_FOUND, tg, now, 0);
                end else begin
                    wf = front_slot() == slot;
                    vld[slot] = 0;
                    push(K_DELETED, tg, now, wf);
                end
            end else begin
                // Fire due timers earliest first, bounded per scan.
                while (n < NFIRE) begin
                    f = front_slot();
                    if (f < 0 || dl[f] > now) break;
                    if (per[f] != 0) dl[f] = sadd(dl[f], per[f]);
                    else vld[f] = 0;
                    push(K_FIRED, tid[f], now, 0);
                    n++;
                end
                if (n == 0) push(K_NONE, 0, now, 0);
            end
            pending[$].last = 1;
        endfunction

        function void check(t_res a);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $display("%0t: kind exp %0d got %0d", $time, e.kind, a.kind); errors++;
            end
            if (a.id !== e.id) begin
                $display("%0t: timer_id exp %h got %h", $time, e.id, a.id); errors++;
            end
            if (a.near !== e.near) begin
                $display("%0t: near_timeout exp %h got %h", $time, e.near, a.near); errors++;
            end
            if (a.empty !== e.empty) begin
                $display("%0t: queue_empty exp %b got %b", $time, e.empty, a.empty); errors++;
            end
            if (a.front !== e.front) begin
                $display("%0t: front_changed exp %b got %b", $time, e.front, a.front); errors++;
            end
            if (a.last !== e.last) begin
                $display("%0t: tlast exp %b got %b", $time, e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [87:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    timer_sb      sb;
    bit           calm = 0;     // no idling on either side while set
    logic [47:0]  clock_ms;     // model time handed to the block
    logic [31:0]  last_id;

    periodic_timer_queue u_top (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Score accepted items on each edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check({m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[82:35],
                      m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast});
    end

    // Receiver stalls about 6% of cycles.
    always @(posedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 6);

    // Hold valid after an accepted item; drop it only while idling.
    task automatic send(t_func fn, logic [47:0] now, logic [31:0] dly,
                        logic [31:0] pr, logic [31:0] tg);
        while (!calm && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'd0, tg, pr, dly, now, fn};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item({6'd0, tg, pr, dly, now, fn});
    endtask

    // Mostly small delays, rare extremes.
    function automatic logic [31:0] pick_span();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return $urandom_range(60);
        endcase
    endfunction

    initial begin
        logic [31:0] tg;
        int r;
        sb = new();
        sb.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty scan, missing delete, saturation, fill to full.
        send(FN_EXP, 0, 0, 0, 0);
        send(FN_DEL, 5, 0, 0, 32'hFFFF_FFFF);
        send(FN_ADD, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send(FN_ADD, 48'hFFFF_FFFF_0000, 32'hFFFF_FFFF, 0, 0);
        for (int i = 0; i < 15; i++) send(FN_ADD, 10, i % 3, i % 2, 0);
        send(FN_EXP, 12, 0, 0, 0);
        send(FN_DEL, 12, 0, 0, 1);
        send(FN_DEL, 12, 0, 0, 2);
        send(t_func'(2'd3), TIME_MAX, 0, 0, 0);
        send(FN_EXP, TIME_MAX, 0, 0, 0);
        for (int i = 1; i <= 20; i++) send(FN_DEL, TIME_MAX, 0, 0, i);

        // Random: time advancing, mixed operations, a calm stretch in the middle.
        clock_ms = 48'($urandom_range(1000));
        for (int n = 0; n < 500; n++) begin
            calm = (n >= 200 && n < 280);
            if ($urandom_range(19) == 0) clock_ms = 48'({$urandom, $urandom});
            else clock_ms = clock_ms + 48'($urandom_range(8));
            r = $urandom_range(99);
            last_id = sb.id_ctr;
            if (r < 40) begin
                send(FN_ADD, clock_ms, pick_span(), ($urandom_range(2) == 0) ? 0 : pick_span(),
                     $urandom);
            end else if (r < 65) begin
                tg = ($urandom_range(3) == 0) ? $urandom : last_id - $urandom_range(20);
                send(FN_DEL, clock_ms, $urandom, $urandom, tg);
            end else begin
                send(t_func'($urandom_range(2, 3)), clock_ms, $urandom, $urandom, $urandom);
            end
        end
        calm = 0;
        s_axis_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/ptq_pkg.sv
src/periodic_timer_queue.sv
verif/tb_periodic_timer_queue.sv
